/* rtl/sha256_pkg.sv */
// Shared types, constants and round functions for the SHA-256 byte hasher.
`timescale 1ns / 1ps
package sha256_pkg;

   localparam int BlockBytes = 64;
   localparam int Rounds     = 64;

   typedef logic [31:0] word_type;
   typedef logic [5:0]  idx_type;

   // Handshake between the top-level controller and the round engine.
   typedef struct packed {
      logic start;     // begin a compression of the block words
      logic busy;      // engine is running rounds
      logic done;      // last round finished, chaining words updated
   } eng_ctl_type;

   localparam word_type INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam idx_type    LEN_OFFSET = 6'd56;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sig1(input word_type x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type bsig0(input word_type x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type bsig1(input word_type x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

/* rtl/sha256_round_engine.sv */
// Iterative SHA-256 compression: one round per cycle over a 16-word schedule window.
`timescale 1ns / 1ps
module sha256_round_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  chain_init,   // load initial hash values
   input  sha256_pkg::word_type  blk_words [16],
   output sha256_pkg::eng_ctl_type ctl,
   output sha256_pkg::word_type  chain [8]
);

   sha256_pkg::word_type w_ff [16];
   sha256_pkg::word_type w_in [16];
   sha256_pkg::word_type v_ff [8];
   sha256_pkg::word_type v_in [8];
   sha256_pkg::word_type h_ff [8];
   sha256_pkg::word_type h_in [8];
   sha256_pkg::idx_type  rnd_ff, rnd_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   sha256_pkg::word_type t1, t2, w_new;

   always_comb begin
      t1 = v_ff[7] + sha256_pkg::bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + sha256_pkg::ROUND_K[rnd_ff] + w_ff[0];
      t2 = sha256_pkg::bsig0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      w_new = sha256_pkg::sig1(w_ff[14]) + w_ff[9] + sha256_pkg::sig0(w_ff[1]) + w_ff[0];
      w_in = w_ff;
      v_in = v_ff;
      h_in = h_ff;
      rnd_in = rnd_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (chain_init) begin
         h_in = sha256_pkg::INIT_H;
      end else if (start && !busy_ff) begin
         w_in = blk_words;
         v_in = h_ff;
         rnd_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // advance the schedule window and the working variables
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
         w_in[15] = w_new;
         for (int i = 7; i > 0; i--) v_in[i] = v_ff[i - 1];
         v_in[4] = v_ff[3] + t1;
         v_in[0] = t1 + t2;
         rnd_in = rnd_ff + 6'd1;
         if (rnd_ff == 6'(sha256_pkg::Rounds - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (done_ff) begin
         for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff  <= '0;
         h_ff    <= sha256_pkg::INIT_H;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         rnd_ff  <= rnd_in;
         h_ff    <= h_in;
      end
      w_ff <= w_in;
      v_ff <= v_in;
   end

   // done passes through done_ff and fin_ff after the last round, arriving together with the updated chain
   logic fin_ff;
   always_ff @(posedge clock) begin
      if (reset) fin_ff <= 1'b0;
      else       fin_ff <= done_ff;
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff | done_ff;
   assign ctl.done  = fin_ff;
   assign chain     = h_ff;

endmodule

/* rtl/sha256_byte_stream_hasher.sv */
// Top level of the SHA-256 byte-stream hasher: intake, padding sequencer and digest output.
`timescale 1ns / 1ps
// Channel | Dir | Beat contents
// req_    | in  | tdata[7:0] msg_byte, tuser op (0 absorb, 1 finish)
// rsp_    | out | tdata[255:0] digest_w0 .. digest_w3, one beat per finish
//
// An absorb beat stores one byte; every 64th byte starts a compression in the
// shared round engine: a start, 64 rounds at one round per cycle and a fold into
// the chain, during all of which req_tready is low. A finish takes one or two
// such compressions (two if 56 or more bytes are held), then holds the digest
// in rsp_ until taken; intake stays closed until then.
// Reset is synchronous, active high, and restores the initial hash values.
module sha256_byte_stream_hasher (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] msg_byte
   input  logic         req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [255:0] rsp_tdata    // [63:0] w0, [127:64] w1, [191:128] w2, [255:192] w3
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_HASH  = 6'b000010,  // full block of message bytes
      ST_PAD1  = 6'b000100,  // padded block, length does not fit
      ST_PAD2  = 6'b001000,  // final block carrying the length
      ST_WAIT  = 6'b010000,  // engine running
      ST_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   state_type next_ff, next_in;      // where to go when the engine finishes

   // block held as 16 big-endian words, byte 4i in the top lane of word i
   sha256_pkg::word_type  store_ff [16];
   sha256_pkg::word_type  store_in [16];
   sha256_pkg::idx_type   fill_ff, fill_in;
   logic [63:0]           bits_ff, bits_in;
   logic [63:0]           total_ff, total_in;
   logic [255:0]          dig_ff, dig_in;

   logic                  eng_start, chain_init;
   sha256_pkg::word_type  blk_words [16];
   sha256_pkg::word_type  chain [8];
   sha256_pkg::eng_ctl_type ctl;

   logic accept;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         blk_words[i] = store_ff[i];
      end
   end

   sha256_round_engine u_eng (
      .clock      (clock),
      .reset      (reset),
      .start      (eng_start),
      .chain_init (chain_init),
      .blk_words  (blk_words),
      .ctl        (ctl),
      .chain      (chain)
   );

   always_comb begin
      state_in   = state_ff;
      next_in    = next_ff;
      store_in   = store_ff;
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      total_in   = total_ff;
      dig_in     = dig_ff;
      eng_start  = 1'b0;
      chain_init = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !req_tuser) begin
               store_in[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] = req_tdata;
               fill_in = fill_ff + 6'd1;
               if (fill_ff == 6'd63) begin
                  bits_in  = bits_ff + 64'd512;
                  state_in = ST_HASH;
               end
            end else if (accept) begin
               total_in = bits_ff + {55'd0, fill_ff, 3'd0};
               // pad: 0x80 then zeros; length goes in only if it fits
               for (int i = 0; i < 64; i++) begin
                  if (6'(i) == fill_ff)
                     store_in[4'(i >> 2)][8 * (3 - (i & 3)) +: 8] = sha256_pkg::PAD_BYTE;
                  else if (6'(i) > fill_ff)
                     store_in[4'(i >> 2)][8 * (3 - (i & 3)) +: 8] = 8'd0;
               end
               if (fill_ff >= sha256_pkg::LEN_OFFSET) begin
                  state_in = ST_PAD1;
               end else begin
                  store_in[14] = total_in[63:32];
                  store_in[15] = total_in[31:0];
                  state_in = ST_PAD2;
               end
            end
         end
         ST_HASH: begin
            eng_start = 1'b1;
            next_in   = ST_IDLE;
            state_in  = ST_WAIT;
         end
         ST_PAD1: begin
            eng_start = 1'b1;
            next_in   = ST_PAD2;
            state_in  = ST_WAIT;
            // zero block with length is loaded once the engine has copied the words
         end
         ST_PAD2: begin
            eng_start = 1'b1;
            next_in   = ST_OUT;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (ctl.done) begin
               if (next_ff == ST_PAD2) begin
                  for (int i = 0; i < 14; i++) store_in[i] = '0;
                  store_in[14] = total_ff[63:32];
                  store_in[15] = total_ff[31:0];
               end else if (next_ff == ST_OUT) begin
                  for (int i = 0; i < 4; i++)
                     dig_in[64 * i +: 64] = {chain[2 * i], chain[2 * i + 1]};
                  chain_init = 1'b1;
                  fill_in    = '0;
                  bits_in    = '0;
               end
               state_in = next_ff;
            end
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         next_ff  <= ST_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
      end else begin
         state_ff <= state_in;
         next_ff  <= next_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
      end
      store_ff <= store_in;
      total_ff <= total_in;
      dig_ff   <= dig_in;
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = dig_ff;

endmodule

/* rtl/sha256_hasher_checker.sv */
// Port-level checker for the SHA-256 byte-stream hasher, bound to the top level.
`timescale 1ns / 1ps
module sha256_hasher_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [255:0] rsp_tdata
);

   // Hold a stalled result steady.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Close intake while a result is offered.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("intake open with result pending");

   // Drop ready after a finish beat.
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready && !rsp_tvalid)
      else $error("finish did not start hashing");

   // An absorb never produces a result next cycle.
   a_absorb_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> !rsp_tvalid)
      else $error("result after absorb");

endmodule

bind sha256_byte_stream_hasher sha256_hasher_checker u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
